// ----- sv/rsi_pkg.sv -----
// Shared constants, field widths and pipeline record types for the
// ray / sphere intersection pipeline. No dependencies.
package rsi_pkg;

    // Fraction bits of the reported distance
    localparam int FRAC_BITS = 16;

    // Coordinate and register widths
    localparam int CRD_W = 32;             // Q16.16 coordinates
    localparam int RAD_W = 31;             // radius register
    localparam int WW    = CRD_W + 1;      // origin minus center
    localparam int AW    = 64;             // a = D.D
    localparam int HW    = 66;             // h = W.D
    localparam int KW    = 67;             // k = W.W - r*r
    localparam int QW    = 132;            // radicand (discriminant)
    localparam int SW    = QW / 2;         // square root
    localparam int NW    = HW + 1;         // root numerator
    localparam int DQ    = 31;             // distance bits
    localparam int CW    = (NW + FRAC_BITS > AW + DQ) ? NW + FRAC_BITS : AW + DQ + 1;

    // Split points of the wide products
    localparam int HS = HW / 2;
    localparam int KS = KW / 2 + 1;
    localparam int AS = AW / 2;

    localparam logic [DQ-1:0]    DIST_MAX   = '1;
    localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(65536);

    // Configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_RADIUS   = 3'd3;

    // Data that rides alongside the square root
    typedef struct packed {
        logic                 miss;
        logic                 t1ok;
        logic signed [HW-1:0] h;
        logic [AW-1:0]        a;
    } t_side;

    // One finished result
    typedef struct packed {
        logic          valid;
        logic          hit;
        logic [DQ-1:0] tdist;
        logic          sat;
    } t_res;

endpackage

// ----- sv/rsi_coef.sv -----
// Coefficient front end: forms a, h, k and the discriminant over seven stages.
// Depends on rsi_pkg.
module rsi_coef (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [rsi_pkg::CRD_W-1:0]  i_org_x,
    input  logic signed [rsi_pkg::CRD_W-1:0]  i_org_y,
    input  logic signed [rsi_pkg::CRD_W-1:0]  i_org_z,
    input  logic signed [rsi_pkg::CRD_W-1:0]  i_dir_x,
    input  logic signed [rsi_pkg::CRD_W-1:0]  i_dir_y,
    input  logic signed [rsi_pkg::CRD_W-1:0]  i_dir_z,
    input  logic signed [rsi_pkg::CRD_W-1:0]  i_ctr_x,
    input  logic signed [rsi_pkg::CRD_W-1:0]  i_ctr_y,
    input  logic signed [rsi_pkg::CRD_W-1:0]  i_ctr_z,
    input  logic [rsi_pkg::RAD_W-1:0]         i_radius,
    output logic                              o_valid,
    output logic [rsi_pkg::QW-1:0]            o_rad,
    output rsi_pkg::t_side                    o_side
);

    localparam int WW = rsi_pkg::WW;
    localparam int CRD_W = rsi_pkg::CRD_W;
    localparam int RAD_W = rsi_pkg::RAD_W;
    localparam int AW = rsi_pkg::AW;
    localparam int HW = rsi_pkg::HW;
    localparam int KW = rsi_pkg::KW;
    localparam int QW = rsi_pkg::QW;
    localparam int HS = rsi_pkg::HS;
    localparam int KS = rsi_pkg::KS;
    localparam int AS = rsi_pkg::AS;

    logic [7:1] r_vld;

    // Stage 1: origin relative to center
    logic signed [WW-1:0]    r1_wx, r1_wy, r1_wz;
    logic signed [CRD_W-1:0] r1_dx, r1_dy, r1_dz;
    logic [RAD_W-1:0]        r1_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_wx <= WW'(i_org_x) - WW'(i_ctr_x);
            r1_wy <= WW'(i_org_y) - WW'(i_ctr_y);
            r1_wz <= WW'(i_org_z) - WW'(i_ctr_z);
            r1_dx <= i_dir_x;
            r1_dy <= i_dir_y;
            r1_dz <= i_dir_z;
            r1_r  <= i_radius;
        end
    end

    // Stage 2: component products
    logic signed [2*CRD_W-1:0] m_dxx, m_dyy, m_dzz;
    logic signed [WW+CRD_W-1:0] m_wdx, m_wdy, m_wdz;
    logic signed [2*WW-1:0]    m_wxx, m_wyy, m_wzz;
    logic [2*RAD_W-1:0]        m_rr;

    assign m_dxx = r1_dx * r1_dx;
    assign m_dyy = r1_dy * r1_dy;
    assign m_dzz = r1_dz * r1_dz;
    assign m_wdx = r1_wx * r1_dx;
    assign m_wdy = r1_wy * r1_dy;
    assign m_wdz = r1_wz * r1_dz;
    assign m_wxx = r1_wx * r1_wx;
    assign m_wyy = r1_wy * r1_wy;
    assign m_wzz = r1_wz * r1_wz;
    assign m_rr  = r1_r * r1_r;

    logic [2*CRD_W-2:0]         r2_dxx, r2_dyy, r2_dzz;
    logic signed [WW+CRD_W-1:0] r2_wdx, r2_wdy, r2_wdz;
    logic signed [2*WW-1:0]     r2_wxx, r2_wyy, r2_wzz;
    logic [2*RAD_W-1:0]         r2_rr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dxx <= m_dxx[2*CRD_W-2:0];
            r2_dyy <= m_dyy[2*CRD_W-2:0];
            r2_dzz <= m_dzz[2*CRD_W-2:0];
            r2_wdx <= m_wdx;
            r2_wdy <= m_wdy;
            r2_wdz <= m_wdz;
            r2_wxx <= m_wxx;
            r2_wyy <= m_wyy;
            r2_wzz <= m_wzz;
            r2_rr  <= m_rr;
        end
    end

    // Stage 3: dot products
    logic [AW-1:0]        r3_a;
    logic signed [HW-1:0] r3_h;
    logic signed [KW-1:0] r3_k;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_a <= AW'(r2_dxx) + AW'(r2_dyy) + AW'(r2_dzz);
            r3_h <= HW'(r2_wdx) + HW'(r2_wdy) + HW'(r2_wdz);
            r3_k <= KW'(r2_wxx) + KW'(r2_wyy) + KW'(r2_wzz) - KW'($signed({1'b0, r2_rr}));
        end
    end

    // Stage 4: magnitudes and root-choice flags
    logic hle, kle;
    assign hle = r3_h[HW-1] || (r3_h == '0);
    assign kle = r3_k[KW-1] || (r3_k == '0);

    logic [HW-1:0]        r4_habs;
    logic [KW-1:0]        r4_kabs;
    logic                 r4_kneg, r4_t1ok, r4_pm;
    logic signed [HW-1:0] r4_h;
    logic [AW-1:0]        r4_a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_habs <= r3_h[HW-1] ? HW'(-r3_h) : HW'(r3_h);
            r4_kabs <= r3_k[KW-1] ? KW'(-r3_k) : KW'(r3_k);
            r4_kneg <= r3_k[KW-1];
            r4_t1ok <= hle && !r3_k[KW-1];
            // zero direction, or both roots behind the origin
            r4_pm   <= (r3_a == '0) || !(hle || kle);
            r4_h    <= r3_h;
            r4_a    <= r3_a;
        end
    end

    // Stage 5: partial products of h*h and a*|k|
    logic [HS-1:0]    hl;
    logic [HW-HS-1:0] hh;
    logic [KS-1:0]    kl;
    logic [KW-KS-1:0] kh;
    logic [AS-1:0]    al;
    logic [AW-AS-1:0] ah;

    assign hl = r4_habs[HS-1:0];
    assign hh = r4_habs[HW-1:HS];
    assign kl = r4_kabs[KS-1:0];
    assign kh = r4_kabs[KW-1:KS];
    assign al = r4_a[AS-1:0];
    assign ah = r4_a[AW-1:AS];

    logic [2*(HW-HS)-1:0]    r5_hhh;
    logic [HW-1:0]           r5_hhl;
    logic [2*HS-1:0]         r5_hll;
    logic [AS+KS-1:0]        r5_k0;
    logic [AS+KW-KS-1:0]     r5_k1;
    logic [AW-AS+KS-1:0]     r5_k2;
    logic [AW-AS+KW-KS-1:0]  r5_k3;
    logic                    r5_kneg, r5_t1ok, r5_pm;
    logic signed [HW-1:0]    r5_h;
    logic [AW-1:0]           r5_a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_hhh  <= (2*(HW-HS))'(hh) * (2*(HW-HS))'(hh);
            r5_hhl  <= HW'(hh) * HW'(hl);
            r5_hll  <= (2*HS)'(hl) * (2*HS)'(hl);
            r5_k0   <= (AS+KS)'(al) * (AS+KS)'(kl);
            r5_k1   <= (AS+KW-KS)'(al) * (AS+KW-KS)'(kh);
            r5_k2   <= (AW-AS+KS)'(ah) * (AW-AS+KS)'(kl);
            r5_k3   <= (AW-AS+KW-KS)'(ah) * (AW-AS+KW-KS)'(kh);
            r5_kneg <= r4_kneg;
            r5_t1ok <= r4_t1ok;
            r5_pm   <= r4_pm;
            r5_h    <= r4_h;
            r5_a    <= r4_a;
        end
    end

    // Stage 6: assemble h*h and a*|k|
    logic [QW-1:0]        r6_h2, r6_ak;
    logic                 r6_kneg, r6_t1ok, r6_pm;
    logic signed [HW-1:0] r6_h;
    logic [AW-1:0]        r6_a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_h2   <= (QW'(r5_hhh) << (2*HS)) + (QW'(r5_hhl) << (HS+1)) + QW'(r5_hll);
            r6_ak   <= (QW'(r5_k3) << (AS+KS)) + (QW'(r5_k2) << AS)
                     + (QW'(r5_k1) << KS) + QW'(r5_k0);
            r6_kneg <= r5_kneg;
            r6_t1ok <= r5_t1ok;
            r6_pm   <= r5_pm;
            r6_h    <= r5_h;
            r6_a    <= r5_a;
        end
    end

    // Stage 7: discriminant and final miss decision
    logic [QW:0] q;
    logic        miss;
    assign q    = r6_kneg ? ({1'b0, r6_h2} + {1'b0, r6_ak}) : ({1'b0, r6_h2} - {1'b0, r6_ak});
    assign miss = r6_pm || q[QW];

    logic [QW-1:0] r7_rad;
    rsi_pkg::t_side r7_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_rad       <= miss ? '0 : q[QW-1:0];
            r7_side.miss <= miss;
            r7_side.t1ok <= r6_t1ok;
            r7_side.h    <= r6_h;
            r7_side.a    <= r6_a;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:1], i_valid};
        end
    end

    assign o_valid = r_vld[7];
    assign o_rad   = r7_rad;
    assign o_side  = r7_side;

endmodule

// ----- sv/rsi_isqrt.sv -----
// Pipelined floor square root, one root bit per stage.
// Depends on rsi_pkg.
module rsi_isqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [rsi_pkg::QW-1:0] i_rad,
    input  rsi_pkg::t_side         i_side,
    output logic                   o_valid,
    output logic [rsi_pkg::SW-1:0] o_root,
    output rsi_pkg::t_side         o_side
);

    localparam int QW = rsi_pkg::QW;
    localparam int SW = rsi_pkg::SW;

    logic           r_vld  [SW];
    logic [QW-1:0]  r_rad  [SW];
    logic [SW+1:0]  r_rem  [SW];
    logic [SW-1:0]  r_root [SW];
    rsi_pkg::t_side r_side [SW];

    for (genvar i = 0; i < SW; i++) begin : g_stg
        logic           vld_in;
        logic [QW-1:0]  rad_in;
        logic [SW+1:0]  rem_in;
        logic [SW-1:0]  root_in;
        rsi_pkg::t_side side_in;
        logic [SW+3:0]  rem2, trial, diff;
        logic           ge;

        if (i == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[i-1];
            assign rad_in  = r_rad[i-1];
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign side_in = r_side[i-1];
        end

        // Bring down two radicand bits and try the next root bit
        assign rem2  = {rem_in, rad_in[QW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (rem2 >= trial);
        assign diff  = rem2 - trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[i]  <= {rad_in[QW-3:0], 2'b00};
                r_rem[i]  <= ge ? diff[SW+1:0] : rem2[SW+1:0];
                r_root[i] <= {root_in[SW-2:0], ge};
                r_side[i] <= side_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= vld_in;
            end
        end
    end

    assign o_valid = r_vld[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_side  = r_side[SW-1];

endmodule

// ----- sv/rsi_div.sv -----
// Root numerator, saturation check and pipelined restoring divide by a,
// one quotient bit per stage. Depends on rsi_pkg.
module rsi_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [rsi_pkg::SW-1:0] i_root,
    input  rsi_pkg::t_side         i_side,
    output rsi_pkg::t_res          o_res
);

    localparam int NW = rsi_pkg::NW;
    localparam int AW = rsi_pkg::AW;
    localparam int CW = rsi_pkg::CW;
    localparam int DQ = rsi_pkg::DQ;

    // Numerator: nearer root that lies ahead of the origin
    logic signed [NW:0] s_mh, s_n;
    assign s_mh = -((NW+1)'(i_side.h));
    assign s_n  = i_side.t1ok ? (s_mh - $signed({1'b0, i_root}))
                              : (s_mh + $signed({1'b0, i_root}));

    logic            r_nvld, r_nmiss;
    logic [NW-1:0]   r_n;
    logic [AW-1:0]   r_na;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n     <= s_n[NW-1:0];
            r_na    <= i_side.a;
            r_nmiss <= i_side.miss;
        end
    end

    // Scale and test for a quotient beyond the distance format
    logic [CW-1:0] numer, lim;
    assign numer = CW'(r_n) << rsi_pkg::FRAC_BITS;
    assign lim   = CW'(r_na) << DQ;

    logic          r_svld, r_smiss, r_ssat;
    logic [CW-1:0] r_snum;
    logic [AW-1:0] r_sa;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_snum  <= numer;
            r_sa    <= r_na;
            r_ssat  <= (numer >= lim);
            r_smiss <= r_nmiss;
        end
    end

    // Quotient stages, most significant bit first
    logic          r_vld  [DQ];
    logic [CW-1:0] r_rem  [DQ];
    logic [AW-1:0] r_a    [DQ];
    logic [DQ-1:0] r_quo  [DQ];
    logic          r_miss [DQ];
    logic          r_sat  [DQ];

    for (genvar j = 0; j < DQ; j++) begin : g_stg
        logic          vld_in, miss_in, sat_in, ge;
        logic [CW-1:0] rem_in, dsor;
        logic [AW-1:0] a_in;
        logic [DQ-1:0] quo_in;

        if (j == 0) begin : g_first
            assign vld_in  = r_svld;
            assign rem_in  = r_snum;
            assign a_in    = r_sa;
            assign quo_in  = '0;
            assign miss_in = r_smiss;
            assign sat_in  = r_ssat;
        end else begin : g_next
            assign vld_in  = r_vld[j-1];
            assign rem_in  = r_rem[j-1];
            assign a_in    = r_a[j-1];
            assign quo_in  = r_quo[j-1];
            assign miss_in = r_miss[j-1];
            assign sat_in  = r_sat[j-1];
        end

        assign dsor = CW'(a_in) << (DQ - 1 - j);
        assign ge   = (rem_in >= dsor);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= ge ? (rem_in - dsor) : rem_in;
                r_a[j]    <= a_in;
                r_quo[j]  <= {quo_in[DQ-2:0], ge};
                r_miss[j] <= miss_in;
                r_sat[j]  <= sat_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end
    end

    // Valid bits of the two front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld <= 1'b0;
            r_svld <= 1'b0;
        end else if (i_en) begin
            r_nvld <= i_valid;
            r_svld <= r_nvld;
        end
    end

    // Shape the result: clamp on overflow, zero on a miss
    always_comb begin
        o_res.valid = r_vld[DQ-1];
        o_res.hit   = !r_miss[DQ-1];
        o_res.sat   = !r_miss[DQ-1] && r_sat[DQ-1];
        if (r_miss[DQ-1]) begin
            o_res.tdist = '0;
        end else if (r_sat[DQ-1]) begin
            o_res.tdist = rsi_pkg::DIST_MAX;
        end else begin
            o_res.tdist = r_quo[DQ-1];
        end
    end

endmodule

// ----- sv/ray_sphere_intersection.sv -----
// Ray / sphere intersection engine. Takes one ray (origin and direction,
// signed Q16.16) per clock and returns one result per ray, in order: hit flag,
// nearest non-negative ray parameter in unsigned Q15.16 and a saturation flag.
// In order, 7 stages form the quadratic coefficients and discriminant, 66
// stages take the square root one bit each, 33 stages form the numerator and
// divide one quotient bit each, plus the output register. Throughput is one
// ray every cycle; the whole pipeline advances together and holds only while
// the skid register behind the output register is full. Sphere center and
// radius are written through the configuration port (index 0..2 center x/y/z,
// 3 radius); the user must write them only while no ray is in flight, as the
// block does not enforce it. Writes are always ready; other indexes are ignored.
// Depends on rsi_pkg, rsi_coef, rsi_isqrt and rsi_div.
module ray_sphere_intersection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // ray input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [rsi_pkg::CRD_W-1:0]    i_origin_x,
    input  logic signed [rsi_pkg::CRD_W-1:0]    i_origin_y,
    input  logic signed [rsi_pkg::CRD_W-1:0]    i_origin_z,
    input  logic signed [rsi_pkg::CRD_W-1:0]    i_dir_x,
    input  logic signed [rsi_pkg::CRD_W-1:0]    i_dir_y,
    input  logic signed [rsi_pkg::CRD_W-1:0]    i_dir_z,
    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [rsi_pkg::DQ-1:0]              o_distance,
    output logic                                o_saturated,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rsi_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [rsi_pkg::CRD_W-1:0]           i_cfg_data
);

    localparam int CRD_W = rsi_pkg::CRD_W;
    localparam int RAD_W = rsi_pkg::RAD_W;

    // Configuration registers
    logic signed [CRD_W-1:0] r_ctr_x, r_ctr_y, r_ctr_z;
    logic [RAD_W-1:0]        r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr_x  <= '0;
            r_ctr_y  <= '0;
            r_ctr_z  <= '0;
            r_radius <= rsi_pkg::RADIUS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rsi_pkg::CFG_CENTER_X: r_ctr_x  <= $signed(i_cfg_data);
                rsi_pkg::CFG_CENTER_Y: r_ctr_y  <= $signed(i_cfg_data);
                rsi_pkg::CFG_CENTER_Z: r_ctr_z  <= $signed(i_cfg_data);
                rsi_pkg::CFG_RADIUS:   r_radius <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the skid register is free
    logic r_skid_vld;
    logic en;
    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;

    logic                   c_vld;
    logic [rsi_pkg::QW-1:0] c_rad;
    rsi_pkg::t_side         c_side;

    rsi_coef u_coef (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_org_x  (i_origin_x),
        .i_org_y  (i_origin_y),
        .i_org_z  (i_origin_z),
        .i_dir_x  (i_dir_x),
        .i_dir_y  (i_dir_y),
        .i_dir_z  (i_dir_z),
        .i_ctr_x  (r_ctr_x),
        .i_ctr_y  (r_ctr_y),
        .i_ctr_z  (r_ctr_z),
        .i_radius (r_radius),
        .o_valid  (c_vld),
        .o_rad    (c_rad),
        .o_side   (c_side)
    );

    logic                   s_vld;
    logic [rsi_pkg::SW-1:0] s_root;
    rsi_pkg::t_side         s_side;

    rsi_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_vld),
        .i_rad   (c_rad),
        .i_side  (c_side),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    rsi_pkg::t_res d_res;

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_vld),
        .i_root  (s_root),
        .i_side  (s_side),
        .o_res   (d_res)
    );

    // Output register with a skid register behind it
    rsi_pkg::t_res r_out, r_skid;
    logic take;
    assign take = r_out.valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
            r_skid_vld  <= 1'b0;
        end else if (r_skid_vld) begin
            // drain the skid entry once the output transfers
            if (take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (d_res.valid) begin
            if (!r_out.valid || take) begin
                r_out <= d_res;
            end else begin
                r_skid     <= d_res;
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_valid     = r_out.valid;
    assign o_hit       = r_out.hit;
    assign o_distance  = r_out.tdist;
    assign o_saturated = r_out.sat;

endmodule
